>>> design/ioc_pkg.sv
// Shared types, constants and helpers for the index of coincidence unit.
// No dependencies.
package ioc_pkg;

  localparam int unsigned MaxLength = 4096;
  localparam int unsigned Letters   = 26;
  localparam int unsigned LastLetter = Letters - 1;
  localparam logic [7:0]  CaseGap   = 8'(int'("a") - int'("A"));
  localparam logic [7:0]  UpperA    = 8'h41;
  localparam logic [7:0]  UpperZ    = 8'h5A;
  localparam logic [7:0]  LowerA    = 8'h61;
  localparam logic [7:0]  LowerZ    = 8'h7A;

  localparam int unsigned LetW   = $clog2(Letters);
  localparam int unsigned CntW   = $clog2(MaxLength + 1);
  localparam int unsigned DenW   = 2 * CntW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned QuotW  = FracW + 1;
  localparam int unsigned StepW  = $clog2(QuotW);

  // fixed field widths of the result item
  localparam int unsigned IndexFieldW = 5;
  localparam int unsigned CountFieldW = 13;
  localparam int unsigned IcFieldW    = 17;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [IndexFieldW-1:0] letter_index;
    logic [CountFieldW-1:0] letter_count;
    logic [IcFieldW-1:0]    coincidence;
    logic                   overflow;
    logic                   end_of_run;
  } out_t;

  typedef struct packed {
    logic            inc_en;
    logic [LetW-1:0] letter;
    logic            shift_en;
    logic            wrap;
  } chain_ctrl_t;

  typedef struct packed {
    logic hit;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic            is_letter;
    logic [LetW-1:0] index;
  } letter_t;

  // case-folded letter decode
  function automatic letter_t letter_of(input logic [7:0] b);
    logic [7:0] u;
    letter_t    r;
    u = b;
    if (b >= LowerA && b <= LowerZ) begin
      u = b - CaseGap;
    end
    r.is_letter = (u >= UpperA && u <= UpperZ);
    r.index     = LetW'(u - UpperA);
    return r;
  endfunction

endpackage

>>> design/ioc_cell.sv
// One letter counter of the counter chain: counts hits, or takes its
// neighbor's count when the chain shifts. Depends on ioc_pkg.
module ioc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ioc_pkg::cell_ctrl_t     ctrl_i,
  input  logic [ioc_pkg::CntW-1:0] nbr_i,
  output logic [ioc_pkg::CntW-1:0] count_o
);
  import ioc_pkg::*;

  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.shift) begin
      count_d = nbr_i;
    end else if (ctrl_i.hit) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

>>> design/ioc_chain.sv
// Row of 26 letter cells. Counts shift toward cell 0 (the head); the tail
// takes either the head (rotate) or zero (drain and clear). Depends on
// ioc_pkg and ioc_cell.
module ioc_chain (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ioc_pkg::chain_ctrl_t     ctrl_i,
  output logic [ioc_pkg::CntW-1:0] head_o
);
  import ioc_pkg::*;

  logic [CntW-1:0] count [Letters];
  logic [CntW-1:0] nbr   [Letters];

  for (genvar k = 0; k < Letters; k++) begin : g_cell
    cell_ctrl_t cc;
    assign cc.hit   = ctrl_i.inc_en && (ctrl_i.letter == LetW'(k));
    assign cc.shift = ctrl_i.shift_en;
    if (k == Letters - 1) begin : g_tail
      assign nbr[k] = ctrl_i.wrap ? count[0] : '0;
    end else begin : g_body
      assign nbr[k] = count[k+1];
    end
    ioc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cc),
      .nbr_i   (nbr[k]),
      .count_o (count[k])
    );
  end

  assign head_o = count[0];

endmodule

>>> design/ioc_divider.sv
// Restoring divider, one quotient bit per cycle, for sum * 2^16 / den when
// sum <= den. Depends on ioc_pkg.
module ioc_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ioc_pkg::DenW-1:0]  num_i,
  input  logic [ioc_pkg::DenW-1:0]  den_i,
  output logic                      done_o,
  output logic [ioc_pkg::QuotW-1:0] quot_o
);
  import ioc_pkg::*;

  logic [DenW:0]    rem_q, rem_d;
  logic [DenW-1:0]  den_q;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [StepW-1:0] step_q;
  logic             busy_q, done_q;
  logic             ge;
  logic [DenW:0]    diff;

  always_comb begin
    ge     = rem_q >= {1'b0, den_q};
    diff   = ge ? (rem_q - {1'b0, den_q}) : rem_q;
    rem_d  = {diff[DenW-1:0], 1'b0};
    quot_d = {quot_q[QuotW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        done_q <= 1'b0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        done_q <= (step_q == StepW'(QuotW - 1));
        if (step_q == StepW'(QuotW - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> design/index_of_coincidence_unit.sv
// Top level of the index of coincidence unit.
// Depends on ioc_pkg, ioc_chain and ioc_divider.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one message byte per
// item, is_last marks the final byte. While a message streams in, one byte
// is taken every cycle. Letters are counted case-insensitively in a chain
// of 26 counter cells; every byte counts toward the length, which stops at
// 4096 bytes and sets the overflow flag for the rest of the message.
// After the last byte, the chain rotates once through a registered
// multiplier to sum f(f-1), then a bit-serial divider forms the Q1.16
// index. The 26 result items (letters A..Z, the index and end_of_run on
// the last) then leave from an output register, one per cycle while
// out_ready_i is high; a stalled receiver simply holds the sweep. The
// chain drains with zeros as it emits, so counters are clear for the
// next message. No byte is taken from the last byte until the 26th
// result has been loaded. Reset clears all counters and flags.
module index_of_coincidence_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ioc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ioc_pkg::out_t out_data_o
);
  import ioc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FLUSH,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [LetW-1:0] cnt_q;
  logic [CntW-1:0] total_q;
  logic            ovf_q;
  logic [DenW-1:0] prod_q, acc_q, den_q;
  logic            prod_vld_q;
  logic [QuotW-1:0] ic_q;
  logic            out_vld_q;
  out_t            out_q;

  logic            in_acc, load;
  letter_t         lt;
  chain_ctrl_t     cctrl;
  logic [CntW-1:0] head;
  logic [CntW-1:0] head_m1;
  logic [DenW-1:0] sq;
  logic [CntW-1:0] total_m1;
  logic            div_done;
  logic [QuotW-1:0] quot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load       = (state_q == ST_EMIT) && (!out_vld_q || out_ready_i);
  assign lt         = letter_of(in_data_i.char_byte);

  always_comb begin
    cctrl.inc_en   = in_acc && lt.is_letter && (total_q != CntW'(MaxLength));
    cctrl.letter   = lt.index;
    cctrl.shift_en = (state_q == ST_SUM) || load;
    cctrl.wrap     = (state_q == ST_SUM);
  end

  ioc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cctrl),
    .head_o (head)
  );

  assign head_m1  = head - CntW'(1);
  assign sq       = (head == '0) ? '0 : DenW'(head) * DenW'(head_m1);
  assign total_m1 = total_q - CntW'(1);

  ioc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .num_i   (acc_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      total_q    <= '0;
      ovf_q      <= 1'b0;
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          acc_q <= '0;
          if (in_acc) begin
            if (total_q == CntW'(MaxLength)) begin
              ovf_q <= 1'b1;
            end else begin
              total_q <= total_q + CntW'(1);
            end
            if (in_data_i.is_last) begin
              state_q <= ST_SUM;
              cnt_q   <= '0;
            end
          end
        end
        ST_SUM: begin
          prod_vld_q <= 1'b1;
          if (prod_vld_q) begin
            acc_q <= acc_q + prod_q;
          end
          cnt_q <= cnt_q + LetW'(1);
          if (cnt_q == LetW'(LastLetter)) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          prod_vld_q <= 1'b0;
          acc_q      <= acc_q + prod_q;
          state_q    <= ST_START;
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            state_q <= ST_EMIT;
            cnt_q   <= '0;
          end
        end
        ST_EMIT: begin
          if (load) begin
            if (cnt_q == LetW'(LastLetter)) begin
              state_q <= ST_IDLE;
              cnt_q   <= '0;
              total_q <= '0;
              ovf_q   <= 1'b0;
            end else begin
              cnt_q <= cnt_q + LetW'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      prod_q <= sq;
      den_q  <= DenW'(total_q) * DenW'(total_m1);
    end
    if (div_done) begin
      // n of 0 or 1 gives a zero index
      ic_q <= (total_q > CntW'(1)) ? quot : '0;
    end
    if (load) begin
      out_q.letter_index <= IndexFieldW'(cnt_q);
      out_q.letter_count <= CountFieldW'(head);
      out_q.coincidence  <= (cnt_q == LetW'(LastLetter)) ? IcFieldW'(ic_q) : '0;
      out_q.overflow     <= ovf_q;
      out_q.end_of_run   <= (cnt_q == LetW'(LastLetter));
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for index_of_coincidence_unit: streams messages in,
// predicts the 26-item letter sweep and Q1.16 index, and checks every item.
// Depends on ioc_pkg and the design sources under design/.
module testbench;
  import ioc_pkg::*;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandomBytes = 420;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 120;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  index_of_coincidence_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  int unsigned letter_tally [Letters];
  int unsigned length_tally;
  bit          overflow_flag;
  out_t        expected_counts [$];

  // run bookkeeping
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned messages_sent;
  int unsigned sweeps_checked;
  int unsigned idle_cycles;
  bit          quiet;     // no idling on either side while set
  bit          hold_req;  // toggled to ask the receiver for a long hold-off

  function automatic int letter_number(logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b >= "a" && b <= "z") begin
      u = b - ("a" - "A");
    end
    if (u >= "A" && u <= "Z") begin
      return int'(u - "A");
    end
    return -1;
  endfunction

  function automatic logic [IcFieldW-1:0] coincidence_q16();
    longint unsigned n;
    longint unsigned pairs;
    longint unsigned q;
    n     = length_tally;
    pairs = 0;
    if (n <= 1) begin
      return '0;
    end
    for (int k = 0; k < Letters; k++) begin
      if (letter_tally[k] > 0) begin
        pairs += longint'(letter_tally[k]) * (letter_tally[k] - 1);
      end
    end
    q = (pairs << 16) / (n * (n - 1));
    if (q > 65536) begin
      q = 65536;
    end
    return q[IcFieldW-1:0];
  endfunction

  function automatic void tally_byte(in_t item);
    int                  idx;
    logic [IcFieldW-1:0] ic;
    out_t                r;
    if (length_tally >= MaxLength) begin
      overflow_flag = 1'b1;
    end else begin
      length_tally++;
      idx = letter_number(item.char_byte);
      if (idx >= 0) begin
        letter_tally[idx]++;
      end
    end
    if (!item.is_last) begin
      return;
    end
    ic = coincidence_q16();
    for (int k = 0; k < Letters; k++) begin
      r.letter_index = IndexFieldW'(k);
      r.letter_count = CountFieldW'(letter_tally[k]);
      r.coincidence  = (k == LastLetter) ? ic : '0;
      r.overflow     = overflow_flag;
      r.end_of_run   = (k == LastLetter);
      expected_counts.push_back(r);
    end
    messages_sent++;
    foreach (letter_tally[k]) begin
      letter_tally[k] = 0;
    end
    length_tally  = 0;
    overflow_flag = 1'b0;
  endfunction

  function automatic in_t make_byte(logic [7:0] b, bit is_last);
    in_t item;
    item.char_byte = b;
    item.is_last   = is_last;
    return item;
  endfunction

  // a letter of either case, from the first `span` letters of the alphabet
  function automatic logic [7:0] random_letter(int unsigned span);
    logic [7:0] base;
    base = $urandom_range(1) ? "a" : "A";
    return base + 8'($urandom_range(span - 1));
  endfunction

  // Starts on the time step after the previous acceptance, returns at the
  // rising edge that accepts this item. Valid stays high between items unless quiet is clear and a random gap is drawn.
  task automatic send_byte(in_t item);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    tally_byte(item);
    bytes_sent++;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    bit          hold_seen;
    hold_left   = 0;
    hold_seen   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        $error("unexpected result item: letter_index %0d", out_data_o.letter_index);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (out_data_o.letter_index !== want.letter_index) begin
          $error("letter_index: expected %0d, got %0d", want.letter_index,
                 out_data_o.letter_index);
          errors++;
        end
        if (out_data_o.letter_count !== want.letter_count) begin
          $error("letter_count: expected %0d, got %0d", want.letter_count,
                 out_data_o.letter_count);
          errors++;
        end
        if (out_data_o.coincidence !== want.coincidence) begin
          $error("coincidence: expected %0d, got %0d", want.coincidence,
                 out_data_o.coincidence);
          errors++;
        end
        if (out_data_o.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_data_o.overflow);
          errors++;
        end
        if (out_data_o.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0d, got %0d", want.end_of_run,
                 out_data_o.end_of_run);
          errors++;
        end
        if (want.end_of_run) begin
          sweeps_checked++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: %0d cycles without an item moving", IdleLimit);
      $display("FAIL index_of_coincidence_unit");
      $finish;
    end
  end

  // single letters, doubled letters and two distinct letters
  task automatic test_short_messages();
    send_byte(make_byte("Z", 1'b1));
    send_byte(make_byte("a", 1'b0));
    send_byte(make_byte("A", 1'b1));
    send_byte(make_byte("a", 1'b0));
    send_byte(make_byte("b", 1'b1));
  endtask

  // letter range edges, neighbors just outside them, and high bytes
  task automatic test_byte_classes();
    logic [7:0] edge_bytes [$];
    edge_bytes = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, "A", "Z", "a", "z",
                   "m", "M", 8'h80, 8'hC1, 8'hE1, 8'h7F};
    foreach (edge_bytes[i]) begin
      send_byte(make_byte(edge_bytes[i], 1'b0));
    end
    send_byte(make_byte("Z", 1'b1));
  endtask

  // receiver holds off while messages keep coming, so the input stalls
  task automatic test_stall();
    hold_req = ~hold_req;
    for (int m = 0; m < 3; m++) begin
      for (int i = 0; i < 8; i++) begin
        send_byte(make_byte(random_letter(26), i == 7));
      end
    end
  endtask

  task automatic test_random();
    int unsigned count;
    int unsigned len;
    int unsigned span;
    int unsigned pick;
    logic [7:0]  b;
    count = 0;
    while (count < RandomBytes) begin
      // first third of the bytes runs with no idling on either side
      quiet = (count < RandomBytes / 3);
      len  = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 120);
      pick = $urandom_range(2);
      span = (pick == 0) ? 26 : ((pick == 1) ? 3 : 1);
      for (int i = 0; i < len; i++) begin
        b = ($urandom_range(99) < 70) ? random_letter(span) : 8'($urandom_range(255));
        send_byte(make_byte(b, i == len - 1));
      end
      count += len;
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors            = 0;
    bytes_sent        = 0;
    messages_sent     = 0;
    sweeps_checked    = 0;
    idle_cycles       = 0;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    length_tally      = 0;
    overflow_flag     = 1'b0;
    foreach (letter_tally[k]) begin
      letter_tally[k] = 0;
    end
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_messages();
    test_byte_classes();
    test_stall();
    test_random();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d messages.", bytes_sent, messages_sent);
    $display("Checked %0d letter sweeps with random stalls and one long hold-off.",
             sweeps_checked);
    if (errors == 0) begin
      $display("PASS index_of_coincidence_unit");
    end else begin
      $display("FAIL index_of_coincidence_unit");
    end
    $finish;
  end

endmodule

>>> index_of_coincidence_unit.f
design/ioc_pkg.sv
design/ioc_cell.sv
design/ioc_chain.sv
design/ioc_divider.sv
design/index_of_coincidence_unit.sv
test/testbench.sv
